/* sv/abst_pkg.sv */
// Shared constants for the array-based binary search tree block.
package abst_pkg;

  localparam int KEY_W = 32;

  // Item opcodes
  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_IN     = 3'd1;
  localparam logic [2:0] MODE_PRE    = 3'd2;
  localparam logic [2:0] MODE_POST   = 3'd3;
  localparam logic [2:0] MODE_LEVEL  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_KEY      = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

endpackage

/* sv/abst_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
module abst_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/array_bst_insert_traverse.sv */
// Top level: binary search tree in a node table, with insert and four traversals.
//
// Usage: drive mode and key and raise start; the beat is taken at a rising edge
// where start is high and busy is low. Results come out on status, out_key and
// last, each present for exactly one cycle while valid is high; there is no
// backpressure, the receiver must take every result. last marks the final
// result of an item.
// Insert: one result (inserted or table full). The walk from the root visits
// one node per cycle; a first node into an empty table or a full table is
// answered straight from idle. Traversal: one result per stored key, or one
// "empty" result. Node visits go through the registered node memory read.
// Post-order first collects keys in reverse into a buffer (pre-order walk)
// and then plays them out one per cycle after an address state. Unused modes
// are taken and give no result.
// busy stays high from the beat until the cycle that carries the last result.
// Reset (rst, synchronous) empties the tree: besides state and valid, only the
// node count is cleared. No clearing pass is needed since slots at or above the
// count are never read and a new node's links are written null when inserted.
module array_bst_insert_traverse #(
  parameter int NODES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic signed [31:0] key,
  output logic               valid,
  output logic [1:0]         status,
  output logic signed [31:0] out_key,
  output logic               last
);

  import abst_pkg::*;

  localparam int IW = $clog2(NODES);      // slot index
  localparam int CW = $clog2(NODES + 1);  // counts up to NODES
  localparam int DW = KEY_W + 2 * IW;     // node word: {key, left, right}

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,       // insert walk, node data for cur present
    S_IN_GO,     // in-order descend left
    S_IN_EMIT,   // in-order emit popped node
    S_POP,       // stack/queue data present, fetch node
    S_PRE,       // pre/post-order visit
    S_LVL,       // level-order visit, push left
    S_LVL_R,     // level-order push right, dequeue
    S_REV_ADDR,  // post-order playback: first address
    S_REV_OUT    // post-order playback
  } state_t;

  state_t state;

  // control registers
  logic [CW-1:0] cnt;   // node_count
  logic [CW-1:0] k;     // keys emitted in this item
  logic [CW-1:0] sp;    // stack top / queue tail
  logic [CW-1:0] head;  // queue head
  logic [IW-1:0] cur;
  logic [IW-1:0] slot;
  logic [IW-1:0] rsave;
  logic [2:0]    md;
  logic signed [KEY_W-1:0] ins_key;

  // memory ports
  logic          node_we;
  logic [IW-1:0] node_waddr, node_raddr;
  logic [DW-1:0] node_wdata, node_rd;
  logic          stk_we;
  logic [IW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rd;
  logic          rev_we;
  logic [IW-1:0] rev_waddr, rev_raddr;
  logic [KEY_W-1:0] rev_wdata, rev_rd;

  abst_ram #(.W(DW), .DEPTH(NODES)) u_node (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rd)
  );

  abst_ram #(.W(IW), .DEPTH(NODES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  abst_ram #(.W(KEY_W), .DEPTH(NODES)) u_rev (
    .clk(clk), .we(rev_we), .waddr(rev_waddr), .wdata(rev_wdata),
    .raddr(rev_raddr), .rdata(rev_rd)
  );

  // node word fields
  logic signed [KEY_W-1:0] nd_key;
  logic [IW-1:0] nd_left, nd_right;
  assign nd_key   = node_rd[DW-1 -: KEY_W];
  assign nd_left  = node_rd[2*IW-1:IW];
  assign nd_right = node_rd[IW-1:0];

  logic          accept, full, greater, last_emit;
  logic [IW-1:0] ins_child, pre_a, pre_b;
  logic [CW-1:0] sp_dec, k_inc, rev_pos;

  assign accept    = start && !busy;
  assign full      = (cnt == CW'(NODES));
  assign greater   = ins_key > nd_key;
  assign ins_child = greater ? nd_right : nd_left;
  assign last_emit = (k == cnt - CW'(1));
  assign sp_dec    = sp - CW'(1);
  assign k_inc     = k + CW'(1);
  assign rev_pos   = cnt - k - CW'(1);
  // pre-order pushes right and visits left next; post-order runs root-right-left
  assign pre_a     = (md == MODE_PRE) ? nd_right : nd_left;
  assign pre_b     = (md == MODE_PRE) ? nd_left : nd_right;
  assign busy      = (state != S_IDLE);

  // memory addressing; node reads are issued ahead of use through the registered read port
  always_comb begin
    node_we    = 1'b0;
    node_waddr = cur;
    node_wdata = node_rd;
    node_raddr = '0;
    stk_we     = 1'b0;
    stk_waddr  = sp[IW-1:0];
    stk_wdata  = cur;
    stk_raddr  = sp_dec[IW-1:0];
    rev_we     = 1'b0;
    rev_waddr  = rev_pos[IW-1:0];
    rev_wdata  = nd_key;
    rev_raddr  = '0;
    case (state)
      S_IDLE: begin
        // new node goes into the first free slot with null links
        if (accept && mode == MODE_INSERT && !full) begin
          node_we    = 1'b1;
          node_waddr = cnt[IW-1:0];
          node_wdata = {key, {IW{1'b0}}, {IW{1'b0}}};
        end
      end
      S_INS: begin
        if (ins_child == '0) begin
          node_we    = 1'b1;
          node_waddr = cur;
          node_wdata = greater ? {nd_key, nd_left, slot} : {nd_key, slot, nd_right};
        end else begin
          node_raddr = ins_child;
        end
      end
      S_IN_GO, S_IN_EMIT: begin
        if (state == S_IN_GO && nd_left != '0) begin
          stk_we     = 1'b1;
          node_raddr = nd_left;
        end else if (nd_right != '0) begin
          node_raddr = nd_right;
        end
      end
      S_POP: begin
        node_raddr = stk_rd;
      end
      S_PRE: begin
        rev_we = (md == MODE_POST);
        if (pre_b != '0) begin
          stk_we     = (pre_a != '0);
          stk_wdata  = pre_a;
          node_raddr = pre_b;
        end else if (pre_a != '0) begin
          node_raddr = pre_a;
        end
      end
      S_LVL: begin
        stk_we    = !last_emit && (nd_left != '0);
        stk_wdata = nd_left;
      end
      S_LVL_R: begin
        stk_raddr = head[IW-1:0];
        stk_wdata = rsave;
        if (head != sp) begin
          stk_we = (rsave != '0);
        end else begin
          node_raddr = rsave;
        end
      end
      S_REV_ADDR: begin
        rev_raddr = '0;
      end
      S_REV_OUT: begin
        rev_raddr = k_inc[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
      cnt   <= '0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            ins_key <= key;
            md      <= mode;
            k       <= '0;
            sp      <= '0;
            head    <= '0;
            cur     <= '0;
            status  <= ST_KEY;
            out_key <= '0;
            last    <= 1'b1;
            case (mode)
              MODE_INSERT: begin
                if (full) begin
                  valid  <= 1'b1;
                  status <= ST_FULL;
                end else begin
                  cnt  <= cnt + CW'(1);
                  slot <= cnt[IW-1:0];
                  if (cnt == '0) begin
                    valid  <= 1'b1;
                    status <= ST_INSERTED;
                  end else begin
                    state <= S_INS;
                  end
                end
              end
              MODE_IN, MODE_PRE, MODE_POST, MODE_LEVEL: begin
                if (cnt == '0) begin
                  valid  <= 1'b1;
                  status <= ST_EMPTY;
                end else if (mode == MODE_IN) begin
                  state <= S_IN_GO;
                end else if (mode == MODE_LEVEL) begin
                  state <= S_LVL;
                end else begin
                  state <= S_PRE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_INS: begin
          if (ins_child == '0) begin
            valid   <= 1'b1;
            status  <= ST_INSERTED;
            out_key <= '0;
            last    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            cur <= ins_child;
          end
        end
        S_IN_GO, S_IN_EMIT: begin
          if (state == S_IN_GO && nd_left != '0) begin
            sp  <= sp + CW'(1);
            cur <= nd_left;
          end else begin
            // no left child: push-then-pop of cur folds into a direct visit
            valid   <= 1'b1;
            status  <= ST_KEY;
            out_key <= nd_key;
            last    <= last_emit;
            k       <= k_inc;
            if (last_emit) begin
              state <= S_IDLE;
            end else if (nd_right != '0) begin
              cur   <= nd_right;
              state <= S_IN_GO;
            end else begin
              sp    <= sp_dec;
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          cur <= stk_rd;
          if (md == MODE_IN) begin
            state <= S_IN_EMIT;
          end else if (md == MODE_LEVEL) begin
            state <= S_LVL;
          end else begin
            state <= S_PRE;
          end
        end
        S_PRE: begin
          valid   <= (md == MODE_PRE);
          status  <= ST_KEY;
          out_key <= nd_key;
          last    <= last_emit;
          k       <= k_inc;
          if (last_emit) begin
            if (md == MODE_PRE) begin
              state <= S_IDLE;
            end else begin
              k     <= '0;
              state <= S_REV_ADDR;
            end
          end else if (pre_b != '0) begin
            if (pre_a != '0) begin
              sp <= sp + CW'(1);
            end
            cur <= pre_b;
          end else if (pre_a != '0) begin
            cur <= pre_a;
          end else begin
            sp    <= sp_dec;
            state <= S_POP;
          end
        end
        S_LVL: begin
          valid   <= 1'b1;
          status  <= ST_KEY;
          out_key <= nd_key;
          last    <= last_emit;
          k       <= k_inc;
          if (last_emit) begin
            state <= S_IDLE;
          end else begin
            if (nd_left != '0) begin
              sp <= sp + CW'(1);
            end
            rsave <= nd_right;
            state <= S_LVL_R;
          end
        end
        S_LVL_R: begin
          if (head != sp) begin
            if (rsave != '0) begin
              sp <= sp + CW'(1);
            end
            head  <= head + CW'(1);
            state <= S_POP;
          end else begin
            // queue empty: the right child is next, skip the queue
            cur   <= rsave;
            state <= S_LVL;
          end
        end
        S_REV_ADDR: begin
          state <= S_REV_OUT;
        end
        S_REV_OUT: begin
          valid   <= 1'b1;
          status  <= ST_KEY;
          out_key <= rev_rd;
          last    <= last_emit;
          k       <= k_inc;
          if (last_emit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // node count never passes the table size
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(NODES))
    else $error("node count beyond table size");

  // a result ends the item exactly when the block goes idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last == !busy))
    else $error("last flag and busy disagree");

  // an insert into a table with room adds exactly one node
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_INSERT && !full) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("insert did not bump node count");

  // stack or queue never holds more entries than nodes
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (sp <= cnt && head <= sp))
    else $error("walk stack pointer out of range");

endmodule
